[hdl/raw_pixel_fetch_unpacker_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the raw pixel fetch unpacker.
// Both forms sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef RAW_PIXEL_FETCH_UNPACKER_TOP_ASSERT_SVH
`define RAW_PIXEL_FETCH_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RPFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rpfu_pkg.sv]
// ---------------------------------------------------------------------------
// rpfu_pkg
// Shared types and codes of the raw pixel fetch unpacker.
// ---------------------------------------------------------------------------
`default_nettype none

package rpfu_pkg;

  // Full width of a computed byte address: row (32b) plus group offset, no wrap.
  localparam int FULL_W        = 34;
  localparam int DEF_ADDR_BITS = 20;

  // format_class codes
  localparam logic [2:0] FMT_NONE  = 3'd0;
  localparam logic [2:0] FMT_8BIT  = 3'd1;
  localparam logic [2:0] FMT_16LE  = 3'd2;
  localparam logic [2:0] FMT_RAW10 = 3'd3;
  localparam logic [2:0] FMT_RAW12 = 3'd4;
  localparam logic [2:0] FMT_RAW14 = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_SHIFT  = 2'd2;

  // transaction modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_FETCH,
    S_DRAIN,
    S_DONE
  } state_t;

  // Byte fetch plan for one pixel read.
  typedef struct packed {
    logic [FULL_W-1:0] addr0;   // MSB / low byte
    logic [FULL_W-1:0] addr1;   // LSB byte (or high byte for 16-bit)
    logic [FULL_W-1:0] addr2;   // second LSB byte, RAW14 only
    logic [1:0]        nbytes;  // 0 for unsupported format
    logic              miss;    // a needed byte lies beyond the store
  } plan_t;

endpackage

`default_nettype wire

[hdl/rpfu_store.sv]
// ---------------------------------------------------------------------------
// rpfu_store
// Single-port byte frame store, one access per cycle, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rpfu_store #(
  parameter int ADDR_BITS = rpfu_pkg::DEF_ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic                 we,
  input  wire logic [7:0]           wdata,
  input  wire logic                 re,
  output logic      [7:0]           rdata
);
  import rpfu_pkg::*;

  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/rpfu_addr_gen.sv]
// ---------------------------------------------------------------------------
// rpfu_addr_gen
// Turns row base, column and format into the list of bytes to fetch.
// ---------------------------------------------------------------------------
`default_nettype none

module rpfu_addr_gen #(
  parameter int ADDR_BITS = rpfu_pkg::DEF_ADDR_BITS
) (
  input  wire logic [2:0]      fmt,
  input  wire logic [31:0]     row,
  input  wire logic [15:0]     x,
  output rpfu_pkg::plan_t      plan
);
  import rpfu_pkg::*;

  localparam int FW = FULL_W;

  logic [17:0]   q4;
  logic [17:0]   q2;
  logic [17:0]   off;
  logic [FW-1:0] g;
  logic [1:0]    k;

  assign q4 = 18'(x[15:2]);
  assign q2 = 18'(x[15:1]);
  assign k  = x[1:0];

  // group offset inside the row: shift-add multiplies by 5 and 3, shift-subtract by 7
  always_comb begin
    case (fmt)
      FMT_8BIT:  off = 18'(x);
      FMT_16LE:  off = 18'(x) << 1;
      FMT_RAW10: off = (q4 << 2) + q4;
      FMT_RAW12: off = (q2 << 1) + q2;
      FMT_RAW14: off = (q4 << 3) - q4;
      default:   off = '0;
    endcase
  end

  assign g = FW'(row) + FW'(off);

  always_comb begin
    plan.addr0  = g;
    plan.addr1  = g;
    plan.addr2  = g;
    plan.nbytes = 2'd0;
    case (fmt)
      FMT_8BIT: begin
        plan.nbytes = 2'd1;
      end
      FMT_16LE: begin
        plan.addr1  = g + FW'(1);
        plan.nbytes = 2'd2;
      end
      FMT_RAW10: begin
        plan.addr0  = g + FW'(k);
        plan.addr1  = g + FW'(4);
        plan.nbytes = 2'd2;
      end
      FMT_RAW12: begin
        plan.addr0  = g + FW'(x[0]);
        plan.addr1  = g + FW'(2);
        plan.nbytes = 2'd2;
      end
      FMT_RAW14: begin
        plan.addr0 = g + FW'(k);
        // LSB bytes holding bits 6k+5..6k of the 24-bit tail word
        case (k)
          2'd0: begin
            plan.addr1  = g + FW'(4);
            plan.nbytes = 2'd2;
          end
          2'd1: begin
            plan.addr1  = g + FW'(4);
            plan.addr2  = g + FW'(5);
            plan.nbytes = 2'd3;
          end
          2'd2: begin
            plan.addr1  = g + FW'(5);
            plan.addr2  = g + FW'(6);
            plan.nbytes = 2'd3;
          end
          default: begin
            plan.addr1  = g + FW'(6);
            plan.nbytes = 2'd2;
          end
        endcase
      end
      default: begin
        plan.nbytes = 2'd0;
      end
    endcase

    // a needed byte at or above the store size
    plan.miss = ((plan.nbytes != 2'd0) && (|plan.addr0[FW-1:ADDR_BITS])) ||
                ((plan.nbytes >= 2'd2) && (|plan.addr1[FW-1:ADDR_BITS])) ||
                ((plan.nbytes == 2'd3) && (|plan.addr2[FW-1:ADDR_BITS]));
  end

endmodule

`default_nettype wire

[hdl/rpfu_unpack.sv]
// ---------------------------------------------------------------------------
// rpfu_unpack
// Assembles fetched bytes into a pixel value and applies the right shift.
// ---------------------------------------------------------------------------
`default_nettype none

module rpfu_unpack (
  input  wire logic [2:0]  fmt,
  input  wire logic [1:0]  k,
  input  wire logic [7:0]  b0,
  input  wire logic [7:0]  b1,
  input  wire logic [7:0]  b2,
  input  wire logic        miss,
  input  wire logic [3:0]  shift,
  output logic      [15:0] value
);
  import rpfu_pkg::*;

  logic [15:0] raw;
  logic [1:0]  lsb2;
  logic [5:0]  lsb6;

  always_comb begin
    case (k)
      2'd0:    lsb2 = b1[1:0];
      2'd1:    lsb2 = b1[3:2];
      2'd2:    lsb2 = b1[5:4];
      default: lsb2 = b1[7:6];
    endcase
  end

  // b1/b2 are the LSB bytes chosen by the address generator
  always_comb begin
    case (k)
      2'd0:    lsb6 = b1[5:0];
      2'd1:    lsb6 = {b2[3:0], b1[7:6]};
      2'd2:    lsb6 = {b2[1:0], b1[7:4]};
      default: lsb6 = b1[7:2];
    endcase
  end

  always_comb begin
    case (fmt)
      FMT_8BIT:  raw = {8'd0, b0};
      FMT_16LE:  raw = {b1, b0};
      FMT_RAW10: raw = {6'd0, b0, lsb2};
      FMT_RAW12: raw = {4'd0, b0, (k[0] ? b1[7:4] : b1[3:0])};
      FMT_RAW14: raw = {2'd0, b0, lsb6};
      default:   raw = '0;
    endcase
  end

  assign value = miss ? 16'd0 : (raw >> shift);

endmodule

`default_nettype wire

[hdl/raw_pixel_fetch_unpacker_top.sv]
// ---------------------------------------------------------------------------
// raw_pixel_fetch_unpacker_top
// Byte frame store with packed raw pixel read-out (8, 16 LE, RAW10/12/14).
// ---------------------------------------------------------------------------
// A write transaction (mode 0) stores one byte; it gives no result. A read
// transaction (mode 1) goes through plan, n fetches, drain and the load of
// the result, where n is the number of bytes the pixel needs: 1 for 8-bit,
// 2 for 16-bit, RAW10, RAW12 and RAW14 pixels 0 and 3, 3 for RAW14 pixels
// 1 and 2. The single-port byte store returns one byte per cycle with a
// registered read. Unsupported formats and reads with an out-of-range byte
// skip the fetches and the drain and go from plan to load. The next
// transaction is accepted in the cycle after the result loads, and a
// stalled output holds the load back. One transaction is in flight at a
// time; a finished result waits in the output register while the next
// transaction is accepted. The store has no reset; configuration is to be
// written only while the block is idle; the block itself does not enforce it.
`default_nettype none

`include "raw_pixel_fetch_unpacker_top_assert.svh"

module raw_pixel_fetch_unpacker_top #(
  parameter int ADDR_BITS = rpfu_pkg::DEF_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [19:0] byte_address,
  input  wire logic [7:0]  byte_value,
  input  wire logic [15:0] pixel_x,
  input  wire logic [15:0] pixel_y,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] pixel_value,
  output logic             out_of_range
);
  import rpfu_pkg::*;

  localparam int FW = FULL_W;

  // configuration registers
  logic [2:0]  format_class;
  logic [15:0] bytes_per_line;
  logic [3:0]  value_shift;

  // control
  state_t state;
  state_t state_next;
  logic   accept;
  logic   mem_we;
  logic   mem_re;
  logic   load_out;
  logic   rd_vld;
  logic [1:0] rd_idx;
  logic [1:0] fetch_idx;

  // datapath
  logic [31:0]          row;
  logic [15:0]          xr;
  plan_t                gen;
  plan_t                plan;
  logic [FW-1:0]        wr_full;
  logic                 wr_ok;
  logic [FW-1:0]        rd_full;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           rd_data;
  logic [7:0]           fetched [3];
  logic [15:0]          value;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      format_class   <= FMT_NONE;
      bytes_per_line <= '0;
      value_shift    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT: format_class   <= cfg_data[2:0];
        REG_STRIDE: bytes_per_line <= cfg_data;
        REG_SHIFT:  value_shift    <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  // ---- sequencer ----------------------------------------------------------
  assign accept = in_valid && in_ready;

  // writes beyond the store are dropped
  assign wr_full = FW'(byte_address);
  assign wr_ok   = ~|wr_full[FW-1:ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == MODE_READ) begin
            state_next = S_PLAN;
          end else begin
            mem_we = wr_ok;
          end
        end
      end
      S_PLAN: begin
        if (gen.miss || (gen.nbytes == 2'd0)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        mem_re = 1'b1;
        if (fetch_idx == plan.nbytes - 2'd1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last byte lands in fetched[] this cycle
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_idx <= '0;
      rd_vld    <= 1'b0;
      rd_idx    <= '0;
    end else begin
      rd_vld <= mem_re;
      rd_idx <= fetch_idx;
      if (state == S_PLAN) begin
        fetch_idx <= '0;
      end else if (mem_re) begin
        fetch_idx <= fetch_idx + 2'd1;
      end
    end
  end

  // ---- row base and fetch plan --------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      row <= {16'd0, pixel_y} * {16'd0, bytes_per_line};
      xr  <= pixel_x;
    end
  end

  rpfu_addr_gen #(
    .ADDR_BITS (ADDR_BITS)
  ) u_addr_gen (
    .fmt  (format_class),
    .row  (row),
    .x    (xr),
    .plan (gen)
  );

  always_ff @(posedge clk) begin
    if (state == S_PLAN) begin
      plan <= gen;
    end
  end

  // ---- frame store --------------------------------------------------------
  always_comb begin
    case (fetch_idx)
      2'd0:    rd_full = plan.addr0;
      2'd1:    rd_full = plan.addr1;
      default: rd_full = plan.addr2;
    endcase
  end

  assign mem_addr = mem_re ? rd_full[ADDR_BITS-1:0] : wr_full[ADDR_BITS-1:0];

  rpfu_store #(
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (byte_value),
    .re    (mem_re),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      fetched[rd_idx] <= rd_data;
    end
  end

  // ---- unpack and result register -----------------------------------------
  rpfu_unpack u_unpack (
    .fmt   (format_class),
    .k     (xr[1:0]),
    .b0    (fetched[0]),
    .b1    (fetched[1]),
    .b2    (fetched[2]),
    .miss  (plan.miss),
    .shift (value_shift),
    .value (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_value  <= value;
      out_of_range <= plan.miss;
    end
  end

  // ---- assertions ---------------------------------------------------------
  `RPFU_ASSERT_NOW(a_port_excl, mem_we, !mem_re, "store read and write in one cycle")
  `RPFU_ASSERT_NOW(a_fetch_plan, state == S_FETCH,
                   !plan.miss && (plan.nbytes != 2'd0), "fetch without a valid plan")
  `RPFU_ASSERT_NOW(a_done_drained, state == S_DONE, !rd_vld, "result loaded before last byte")
  `RPFU_ASSERT_NEXT(a_miss_zero, load_out && plan.miss,
                    out_of_range && (pixel_value == 16'd0), "out-of-range result not zero")

endmodule

`default_nettype wire

[test/tb_raw_pixel_fetch_unpacker_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_raw_pixel_fetch_unpacker_top
// Self-checking bench for the raw pixel fetch unpacker. A short table of
// directed transactions hits the store edges, every format and the
// out-of-range and unsupported-format answers. Random phases follow, each
// with its own register setting and one of three back-pressure mixes. Read
// results come typed in or predicted from a shadow store, compared in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_raw_pixel_fetch_unpacker_top;
  import rpfu_pkg::*;

  // Format codes the block treats as unsupported, besides FMT_NONE.
  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;

  localparam int          CALC_W      = 40;             // no wrap in address math
  localparam longint      STORE_BYTES = 64'd1 << DEF_ADDR_BITS;
  localparam int          SETTLE      = 12;             // > worst read latency
  localparam int          QUIET_LIMIT = 4000;           // cycles with no transaction
  localparam int          PHASES      = 18;
  localparam int          PHASE_ITEMS = 22;

  typedef struct packed {
    logic [15:0] pixel;
    logic        oor;
  } pixel_result_t;

  // Bytes one read needs, in the order the unpacking uses them.
  typedef struct packed {
    logic [CALC_W-1:0] a0;     // MSB byte (low byte for 16-bit)
    logic [CALC_W-1:0] a1;     // LSB byte (high byte for 16-bit)
    logic [CALC_W-1:0] a2;     // second LSB byte, RAW14 pixels 1 and 2
    logic [1:0]        count;  // 0: unsupported format
    logic              miss;   // some needed byte lies beyond the store
  } byte_fetch_t;

  // One row of the directed table. The register fields apply to read rows.
  typedef struct packed {
    logic [2:0]    fmt;
    logic [15:0]   stride;
    logic [3:0]    shift;
    logic          mode;
    logic [19:0]   addr;
    logic [7:0]    value;
    logic [15:0]   x;
    logic [15:0]   y;
    logic          has_value;  // expected result typed in below
    pixel_result_t result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset setting: unsupported format answers 0 even at the far corner
    '{FMT_NONE,  16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'hFFFF, 16'hFFFF, 1'b1,
      '{16'h0000, 1'b0}},
    '{FMT_NONE,  16'd0,     4'd0,  MODE_WRITE, 20'h00000, 8'hFF, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_NONE,  16'd0,     4'd0,  MODE_WRITE, 20'hFFFFF, 8'hA5, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_8BIT,  16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd0,    16'd0,    1'b1,
      '{16'h00FF, 1'b0}},
    // last byte of the store, then the first byte past it
    '{FMT_8BIT,  16'd16,    4'd0,  MODE_READ,  20'h0, 8'h0,  16'd15,   16'hFFFF, 1'b1,
      '{16'h00A5, 1'b0}},
    '{FMT_8BIT,  16'd16,    4'd0,  MODE_READ,  20'h0, 8'h0,  16'd16,   16'hFFFF, 1'b1,
      '{16'h0000, 1'b1}},
    // stride, shift and coordinates at their maximum
    '{FMT_8BIT,  16'hFFFF,  4'd15, MODE_READ,  20'h0, 8'h0,  16'hFFFF, 16'hFFFF, 1'b1,
      '{16'h0000, 1'b1}},
    '{FMT_8BIT,  16'hFFFF,  4'd15, MODE_WRITE, 20'hFFFFE, 8'h5A, 16'h0, 16'h0, 1'b0, '0},
    // 16-bit word at the top of the store, 0xA55A >> 15
    '{FMT_16LE,  16'd16,    4'd15, MODE_READ,  20'h0, 8'h0,  16'd7,    16'hFFFF, 1'b1,
      '{16'h0001, 1'b0}},
    // low byte is the last store byte, high byte falls beyond
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_READ,  20'h0, 8'h0,  16'd32775, 16'd15,  1'b1,
      '{16'h0000, 1'b1}},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00001, 8'h3C, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00002, 8'hC3, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00003, 8'h96, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00004, 8'hE4, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00005, 8'h5B, 16'h0, 16'h0, 1'b0, '0},
    '{FMT_16LE,  16'hFFFF,  4'd0,  MODE_WRITE, 20'h00006, 8'hD2, 16'h0, 16'h0, 1'b0, '0},
    // packed formats on the group at address 0
    '{FMT_RAW10, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd1,    16'd0,    1'b0, '0},
    '{FMT_RAW10, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd3,    16'd0,    1'b0, '0},
    '{FMT_RAW12, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd0,    16'd0,    1'b0, '0},
    '{FMT_RAW12, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd1,    16'd0,    1'b0, '0},
    '{FMT_RAW14, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd1,    16'd0,    1'b0, '0},
    '{FMT_RAW14, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd2,    16'd0,    1'b0, '0},
    '{FMT_RAW14, 16'd0,     4'd0,  MODE_READ,  20'h0, 8'h0,  16'd3,    16'd0,    1'b0, '0},
    // RAW14 MSB byte inside the store, its LSB byte beyond
    '{FMT_RAW14, 16'd16,    4'd0,  MODE_READ,  20'h0, 8'h0,  16'd8,    16'hFFFF, 1'b1,
      '{16'h0000, 1'b1}}
  };

  // DUT ports; every input has a known value from time zero.
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = REG_FORMAT;
  logic [15:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        mode         = MODE_WRITE;
  logic [19:0] byte_address = '0;
  logic [7:0]  byte_value   = '0;
  logic [15:0] pixel_x      = '0;
  logic [15:0] pixel_y      = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] pixel_value;
  logic        out_of_range;

  // Shadow state: register copies and the bytes written so far.
  logic [2:0]  cur_fmt    = FMT_NONE;
  logic [15:0] cur_stride = '0;
  logic [3:0]  cur_shift  = '0;
  logic [7:0]  frame_bytes [int unsigned];

  pixel_result_t expected_pixels [$];
  int unsigned   failures      = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   phase_sent    = 0;
  int unsigned   valid_gap_pct = 0;
  int unsigned   ready_stall_pct = 0;

  raw_pixel_fetch_unpacker_top i_dut (.*);

  always #5 clk = ~clk;

  // Receiver: out_ready drops at random per cycle, as the phase dictates.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Which store bytes a read of (x, y) touches under the current setting.
  function automatic byte_fetch_t fetch_plan(input logic [15:0] x, input logic [15:0] y);
    byte_fetch_t       f;
    logic [CALC_W-1:0] row;
    logic [CALC_W-1:0] grp;
    int unsigned       k;
    int unsigned       lo_bit;
    f     = '0;
    row   = CALC_W'(y) * CALC_W'(cur_stride);
    k     = 32'(x[1:0]);
    case (cur_fmt)
      FMT_8BIT: begin
        f.a0 = row + CALC_W'(x);
        f.count = 2'd1;
      end
      FMT_16LE: begin
        grp = row + 2 * CALC_W'(x);
        f.a0 = grp;
        f.a1 = grp + 1;
        f.count = 2'd2;
      end
      FMT_RAW10: begin
        grp = row + CALC_W'(x >> 2) * 5;
        f.a0 = grp + k;
        f.a1 = grp + 4;
        f.count = 2'd2;
      end
      FMT_RAW12: begin
        grp = row + CALC_W'(x >> 1) * 3;
        f.a0 = x[0] ? grp + 1 : grp;
        f.a1 = grp + 2;
        f.count = 2'd2;
      end
      FMT_RAW14: begin
        // LSB word is 24 bits; pixels 1 and 2 straddle two of its bytes
        grp    = row + CALC_W'(x >> 2) * 7;
        lo_bit = 6 * k;
        f.a0   = grp + k;
        f.a1   = grp + 4 + (lo_bit >> 3);
        f.a2   = grp + 4 + ((lo_bit + 5) >> 3);
        f.count = ((lo_bit >> 3) == ((lo_bit + 5) >> 3)) ? 2'd2 : 2'd3;
      end
      default: f.count = 2'd0;
    endcase
    f.miss = (f.count >= 1 && f.a0 >= STORE_BYTES) ||
             (f.count >= 2 && f.a1 >= STORE_BYTES) ||
             (f.count == 3 && f.a2 >= STORE_BYTES);
    return f;
  endfunction

  function automatic pixel_result_t unpack_pixel(input logic [15:0] x, input logic [15:0] y);
    byte_fetch_t   f;
    pixel_result_t r;
    int unsigned   b0, b1, b2, k, lo_bit, word, raw;
    f  = fetch_plan(x, y);
    r  = '0;
    b0 = 0;
    b1 = 0;
    b2 = 0;
    if (f.count == 0) return r;
    if (f.miss) begin
      r.oor = 1'b1;
      return r;
    end
    b0 = 32'(frame_bytes[32'(f.a0)]);
    if (f.count >= 2) b1 = 32'(frame_bytes[32'(f.a1)]);
    if (f.count == 3) b2 = 32'(frame_bytes[32'(f.a2)]);
    k      = 32'(x[1:0]);
    lo_bit = 6 * k;
    case (cur_fmt)
      FMT_8BIT:  raw = b0;
      FMT_16LE:  raw = b0 | (b1 << 8);
      FMT_RAW10: raw = (b0 << 2) | ((b1 >> (2 * k)) & 32'h3);
      FMT_RAW12: raw = x[0] ? ((b0 << 4) | (b1 >> 4)) : ((b0 << 4) | (b1 & 32'h0F));
      default: begin
        word = (b1 << (8 * (lo_bit >> 3))) | (b2 << (8 * ((lo_bit + 5) >> 3)));
        raw  = (b0 << 6) | ((word >> lo_bit) & 32'h3F);
      end
    endcase
    r.pixel = 16'(raw) >> cur_shift;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // Present one transaction and wait for the handshake. The shadow store and
  // the expected results are updated at the accepting edge.
  task automatic send_item(input logic m, input logic [19:0] a, input logic [7:0] v,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic has_value, input pixel_result_t typed);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < valid_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    byte_address <= a;
    byte_value   <= v;
    pixel_x      <= x;
    pixel_y      <= y;
    do @(posedge clk); while (!in_ready);
    phase_sent++;
    if (m == MODE_WRITE) begin
      if (64'(a) < STORE_BYTES) frame_bytes[32'(a)] = v;
    end else begin
      expected_pixels.push_back(has_value ? typed : unpack_pixel(x, y));
    end
  endtask

  // Wait until every read has answered, then give a trailing write time to retire.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_registers(input logic [2:0] fmt, input logic [15:0] stride,
                                   input logic [3:0] shift);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FORMAT;
    cfg_data  <= 16'(fmt);
    @(posedge clk);
    cur_fmt   = fmt;
    cfg_index <= REG_STRIDE;
    cfg_data  <= stride;
    @(posedge clk);
    cur_stride = stride;
    cfg_index <= REG_SHIFT;
    cfg_data  <= 16'(shift);
    @(posedge clk);
    cur_shift = shift;
    cfg_we    <= 1'b0;
  endtask

  // Write a byte the next read needs if it was never written; sometimes
  // overwrite it anyway so stored content keeps changing.
  task automatic prime_byte(input logic [CALC_W-1:0] a);
    if (!frame_bytes.exists(32'(a)) || $urandom_range(0, 3) == 0)
      send_item(MODE_WRITE, a[19:0], 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  task automatic random_transaction();
    int unsigned pick;
    int unsigned ymax;
    logic [15:0] x;
    logic [15:0] y;
    byte_fetch_t f;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // stray byte write anywhere in the store
      send_item(MODE_WRITE, 20'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                1'b0, '0);
    end else begin
      if (pick < 25) begin
        // unconstrained coordinates: mostly beyond the store unless stride is tiny
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        // aim at rows that start inside the store
        if (cur_stride == 0) begin
          y = 16'($urandom);
        end else begin
          ymax = 32'((STORE_BYTES - 1) / cur_stride);
          if (ymax > 65535) ymax = 65535;
          y = 16'($urandom_range(0, ymax));
        end
        x = $urandom_range(0, 1) ? 16'($urandom_range(0, 63)) : 16'($urandom);
      end
      // never let the block read a store byte that holds nothing yet
      f = fetch_plan(x, y);
      if (f.count != 0 && !f.miss) begin
        prime_byte(f.a0);
        if (f.count >= 2) prime_byte(f.a1);
        if (f.count == 3) prime_byte(f.a2);
      end
      send_item(MODE_READ, 20'($urandom), 8'($urandom), x, y, 1'b0, '0);
    end
  endtask

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no read outstanding: pixel_value %h out_of_range %b",
               pixel_value, out_of_range);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_value !== want.pixel) begin
          $error("pixel_value: expected %h, got %h", want.pixel, pixel_value);
          failures++;
        end
        if (out_of_range !== want.oor) begin
          $error("out_of_range: expected %b, got %b", want.oor, out_of_range);
          failures++;
        end
      end
    end
  end

  // Watchdog: a stretch with no transaction on any port means a hang.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [2:0]  fmt;
    logic [15:0] stride;
    logic [3:0]  shift;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table under heavy back-pressure. Registers change only
    // between reads, and only when a read row asks for another setting.
    valid_gap_pct   = 19;
    ready_stall_pct = 56;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode == MODE_READ &&
          {DIRECTED[i].fmt, DIRECTED[i].stride, DIRECTED[i].shift} !=
          {cur_fmt, cur_stride, cur_shift})
        program_registers(DIRECTED[i].fmt, DIRECTED[i].stride, DIRECTED[i].shift);
      send_item(DIRECTED[i].mode, DIRECTED[i].addr, DIRECTED[i].value, DIRECTED[i].x,
                DIRECTED[i].y, DIRECTED[i].has_value, DIRECTED[i].result);
    end

    // Random phases: six per idling mix, every format class in each mix.
    for (int p = 0; p < PHASES; p++) begin
      case (p / 6)
        0:       begin valid_gap_pct = 19; ready_stall_pct = 56; end
        1:       begin valid_gap_pct = 56; ready_stall_pct = 19; end
        default: begin valid_gap_pct = 0;  ready_stall_pct = 0;  end
      endcase
      case (p % 6)
        0: begin
          case ($urandom_range(0, 2))
            0:       fmt = FMT_NONE;
            1:       fmt = FMT_RSVD6;
            default: fmt = FMT_RSVD7;
          endcase
        end
        1:       fmt = FMT_8BIT;
        2:       fmt = FMT_16LE;
        3:       fmt = FMT_RAW10;
        4:       fmt = FMT_RAW12;
        default: fmt = FMT_RAW14;
      endcase
      case ($urandom_range(0, 4))
        0:       stride = 16'd0;
        1:       stride = 16'hFFFF;
        2, 3:    stride = 16'($urandom_range(1, 64));
        default: stride = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       shift = 4'd15;
        1, 2:    shift = 4'd0;
        default: shift = 4'($urandom);
      endcase
      program_registers(fmt, stride, shift);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) random_transaction();
    end

    drain_pipeline();
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/rpfu_pkg.sv
hdl/rpfu_store.sv
hdl/rpfu_addr_gen.sv
hdl/rpfu_unpack.sv
hdl/raw_pixel_fetch_unpacker_top.sv
test/tb_raw_pixel_fetch_unpacker_top.sv
